@@ design/assert_macros.svh @@
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CHB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define CHB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/chb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chb_pkg
// Types and constants for the client heartbeat timeout table.
// ----------------------------------------------------------------------------
package chb_pkg;

  localparam int unsigned ID_W        = 8;
  localparam int unsigned CLIENT_W    = 6;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5;

  localparam logic ACT_PING = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic EV_JOINED = 1'b0;
  localparam logic EV_LOST   = 1'b1;

  typedef logic [TIME_W-1:0] time_t;

endpackage

@@ design/client_heartbeat_timeout_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_heartbeat_timeout_table_top
// Client liveness table: pings mark clients present, ticks scan for timeouts.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// command   in         start && !busy            action, client_id, is_server
// event     out        event_valid_o (strobe)    kind, client, server, last
// config    in         cfg_valid_i & cfg_ready_o timeout_ticks (cfg_data_i)
//
// Ping: accepted while idle, busy stays low; joined event in the cycle after.
// Tick: busy while the slots are scanned, one last-seen RAM read per slot;
//   the scan ends early when MAX_RESULTS lost events are reached first.
// Reset clears the present bits at once; the last-seen RAM needs no clearing.
// Events cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module client_heartbeat_timeout_table_top #(
  parameter int unsigned CLIENT_SLOTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic [chb_pkg::ID_W-1:0]      client_id_i,
  input  logic                          is_server_i,
  output logic                          event_valid_o,
  output logic                          event_kind_o,
  output logic [chb_pkg::CLIENT_W-1:0]  event_client_o,
  output logic                          event_server_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [chb_pkg::TIME_W-1:0]    cfg_data_i
);

  import chb_pkg::*;

  localparam int unsigned IDX_W  = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int unsigned SCAN_W = $clog2(CLIENT_SLOTS + 1);

  typedef enum logic {S_IDLE, S_SCAN} state_e;

  state_e                  state_q, state_d;
  time_t                   now_q, now_d;
  time_t                   timeout_q, timeout_d;
  logic [CLIENT_SLOTS-1:0] present_q, present_d;
  logic [SCAN_W-1:0]       issue_q, issue_d;
  logic                    chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]        chk_idx_q, chk_idx_d;
  logic                    pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]        pend_idx_q, pend_idx_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    stop_q, stop_d;
  logic                    ev_vld_q, ev_vld_d;
  logic                    ev_kind_q, ev_kind_d;
  logic [CLIENT_W-1:0]     ev_client_q, ev_client_d;
  logic                    ev_server_q, ev_server_d;
  logic                    ev_last_q, ev_last_d;

  logic                    ram_we;
  logic [IDX_W-1:0]        ping_idx;
  time_t                   ram_rdata;
  time_t                   age;
  logic                    chk_expired;
  logic                    scan_more;
  logic [ID_W-1:0]         pend_id;

  assign ping_idx    = client_id_i[IDX_W-1:0];
  assign age         = now_q - ram_rdata;
  assign chk_expired = chk_vld_q && present_q[chk_idx_q] && (age > timeout_q);
  assign scan_more   = issue_q < SCAN_W'(CLIENT_SLOTS);
  assign pend_id     = ID_W'(pend_idx_q);

  chb_ram #(
    .WIDTH (TIME_W),
    .DEPTH (CLIENT_SLOTS)
  ) u_seen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ping_idx),
    .wdata_i (now_q),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    timeout_d   = timeout_q;
    present_d   = present_q;
    issue_d     = issue_q;
    chk_vld_d   = chk_vld_q;
    chk_idx_d   = chk_idx_q;
    pend_vld_d  = pend_vld_q;
    pend_idx_d  = pend_idx_q;
    cnt_d       = cnt_q;
    stop_d      = stop_q;
    ev_vld_d    = 1'b0;
    ev_kind_d   = ev_kind_q;
    ev_client_d = ev_client_q;
    ev_server_d = ev_server_q;
    ev_last_d   = ev_last_q;
    ram_we      = 1'b0;

    if (cfg_valid_i) begin
      timeout_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (action_i == ACT_TICK) begin
            now_d      = now_q + 1'b1;
            state_d    = S_SCAN;
            issue_d    = '0;
            chk_vld_d  = 1'b0;
            pend_vld_d = 1'b0;
            cnt_d      = '0;
            stop_d     = 1'b0;
          end else if (client_id_i < ID_W'(CLIENT_SLOTS)) begin
            ram_we              = 1'b1;
            present_d[ping_idx] = 1'b1;
            if (!present_q[ping_idx]) begin
              ev_vld_d    = 1'b1;
              ev_kind_d   = EV_JOINED;
              ev_client_d = client_id_i[CLIENT_W-1:0];
              ev_server_d = is_server_i;
              ev_last_d   = 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        if (stop_q || (!scan_more && !chk_vld_q)) begin
          // flush the held-back event as the final one
          if (pend_vld_q) begin
            ev_vld_d    = 1'b1;
            ev_kind_d   = EV_LOST;
            ev_client_d = pend_id[CLIENT_W-1:0];
            ev_server_d = 1'b0;
            ev_last_d   = 1'b1;
          end
          pend_vld_d = 1'b0;
          chk_vld_d  = 1'b0;
          state_d    = S_IDLE;
        end else begin
          chk_vld_d = scan_more;
          chk_idx_d = issue_q[IDX_W-1:0];
          if (scan_more) begin
            issue_d = issue_q + 1'b1;
          end
          if (chk_expired) begin
            present_d[chk_idx_q] = 1'b0;
            cnt_d      = cnt_q + 1'b1;
            pend_vld_d = 1'b1;
            pend_idx_d = chk_idx_q;
            if (pend_vld_q) begin
              ev_vld_d    = 1'b1;
              ev_kind_d   = EV_LOST;
              ev_client_d = pend_id[CLIENT_W-1:0];
              ev_server_d = 1'b0;
              ev_last_d   = 1'b0;
            end
            if (cnt_q == CNT_W'(MAX_RESULTS - 1)) begin
              stop_d = 1'b1;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      now_q      <= '0;
      timeout_q  <= TIMEOUT_RESET;
      present_q  <= '0;
      issue_q    <= '0;
      chk_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
      stop_q     <= 1'b0;
      ev_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      now_q      <= now_d;
      timeout_q  <= timeout_d;
      present_q  <= present_d;
      issue_q    <= issue_d;
      chk_vld_q  <= chk_vld_d;
      pend_vld_q <= pend_vld_d;
      cnt_q      <= cnt_d;
      stop_q     <= stop_d;
      ev_vld_q   <= ev_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    pend_idx_q  <= pend_idx_d;
    ev_kind_q   <= ev_kind_d;
    ev_client_q <= ev_client_d;
    ev_server_q <= ev_server_d;
    ev_last_q   <= ev_last_d;
  end

  assign busy           = (state_q == S_SCAN);
  assign cfg_ready_o    = 1'b1;
  assign event_valid_o  = ev_vld_q;
  assign event_kind_o   = ev_kind_q;
  assign event_client_o = ev_client_q;
  assign event_server_o = ev_server_q;
  assign last_o         = ev_last_q;

  `CHB_ASSERT_NXT(a_tick_goes_busy, start && !busy && (action_i == ACT_TICK), busy,
                  "tick accepted without entering scan")
  `CHB_ASSERT_IMP(a_joined_is_last, ev_vld_q && (ev_kind_q == EV_JOINED), ev_last_q && !$past(busy),
                  "joined event not single or raised during scan")
  `CHB_ASSERT_IMP(a_lost_from_scan, ev_vld_q && (ev_kind_q == EV_LOST), $past(busy) && !ev_server_q,
                  "lost event outside a scan")
  `CHB_ASSERT_IMP(a_held_event_flushed, $fell(busy), !pend_vld_q,
                  "scan ended with an event still held")

endmodule

@@ design/chb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sim/chb_event_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chb_event_checker
// Event predictor and scoreboard for the client heartbeat timeout table.
// Follows every accepted command and config transaction. Keeps its own copy of
// the present bits, last-seen times, tick counter and timeout. Queues the
// joined and lost events each command should cause and compares each strobed
// event, field by field, with the oldest one queued.
// ----------------------------------------------------------------------------
module chb_event_checker #(
  parameter int unsigned CLIENT_SLOTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic                          action_i,
  input  logic [chb_pkg::ID_W-1:0]      client_id_i,
  input  logic                          is_server_i,
  input  logic                          event_valid_i,
  input  logic                          event_kind_i,
  input  logic [chb_pkg::CLIENT_W-1:0]  event_client_i,
  input  logic                          event_server_i,
  input  logic                          last_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [chb_pkg::TIME_W-1:0]    cfg_data_i,
  output int unsigned                   mismatches_o,
  output int unsigned                   pending_o
);
  import chb_pkg::*;

  typedef struct packed {
    logic                kind;
    logic [CLIENT_W-1:0] client;
    logic                server;
    logic                last;
  } chb_event_t;

  chb_event_t              expected_events[$];
  time_t                   timeout_ticks;
  time_t                   now_ticks;
  time_t                   seen_time[CLIENT_SLOTS];
  logic [CLIENT_SLOTS-1:0] present;

  task automatic predict_events(input logic act, input logic [ID_W-1:0] id,
                                input logic srv);
    chb_event_t ev;
    chb_event_t batch[$];
    time_t      age;
    if (act == ACT_PING) begin
      if (id < CLIENT_SLOTS) begin
        seen_time[id] = now_ticks;
        if (!present[id]) begin
          present[id] = 1'b1;
          ev.kind   = EV_JOINED;
          ev.client = id[CLIENT_W-1:0];
          ev.server = srv;
          ev.last   = 1'b0;
          batch.push_back(ev);
        end
      end
    end else begin
      now_ticks = now_ticks + 1;
      for (int i = 0; i < CLIENT_SLOTS && batch.size() < MAX_RESULTS; i++) begin
        age = now_ticks - seen_time[i];
        if (present[i] && age > timeout_ticks) begin
          present[i] = 1'b0;
          ev.kind   = EV_LOST;
          ev.client = i[CLIENT_W-1:0];
          ev.server = 1'b0;
          ev.last   = 1'b0;
          batch.push_back(ev);
        end
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) expected_events.push_back(batch[k]);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    chb_event_t want;
    if (!rst_ni) begin
      timeout_ticks = TIMEOUT_RESET;
      now_ticks     = '0;
      present       = '0;
      foreach (seen_time[i]) seen_time[i] = '0;
      expected_events.delete();
      mismatches_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) timeout_ticks = cfg_data_i;
      if (start_i && !busy_i) predict_events(action_i, client_id_i, is_server_i);
      if (event_valid_i) begin
        if (expected_events.size() == 0) begin
          $error("unexpected event: kind %0d client %0d server %0d last %0d",
                 event_kind_i, event_client_i, event_server_i, last_i);
          mismatches_o++;
        end else begin
          want = expected_events.pop_front();
          compare_field("event_kind", 32'(want.kind), 32'(event_kind_i));
          compare_field("event_client", 32'(want.client), 32'(event_client_i));
          compare_field("event_server", 32'(want.server), 32'(event_server_i));
          compare_field("last", 32'(want.last), 32'(last_i));
        end
      end
    end
    pending_o = expected_events.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the client heartbeat timeout table.
// A directed run covers joins, repeat pings, out-of-range ids, lost events on
// one tick, zero and maximum timeouts. Random phases follow, each with its own
// timeout, then a sweep that fills the whole table and loses every client on
// one tick. Start is dropped for random gaps. The checker beside the block
// scores every event.
// ----------------------------------------------------------------------------
module testbench;
  import chb_pkg::*;

  localparam int unsigned CLIENT_SLOTS = 64;
  localparam int unsigned DRAIN_CYCLES = CLIENT_SLOTS + 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 3;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  logic                 action_i    = ACT_PING;
  logic [ID_W-1:0]      client_id_i = '0;
  logic                 is_server_i = 1'b0;
  logic                 event_valid_o;
  logic                 event_kind_o;
  logic [CLIENT_W-1:0]  event_client_o;
  logic                 event_server_o;
  logic                 last_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [TIME_W-1:0]    cfg_data_i  = '0;

  int unsigned          mismatches;
  int unsigned          pending;
  int unsigned          cycle_count = 0;
  bit                   no_gaps     = 1'b0;

  always #5 clk_i = ~clk_i;

  client_heartbeat_timeout_table_top #(
    .CLIENT_SLOTS(CLIENT_SLOTS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .client_id_i   (client_id_i),
    .is_server_i   (is_server_i),
    .event_valid_o (event_valid_o),
    .event_kind_o  (event_kind_o),
    .event_client_o(event_client_o),
    .event_server_o(event_server_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  chb_event_checker #(
    .CLIENT_SLOTS(CLIENT_SLOTS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .action_i      (action_i),
    .client_id_i   (client_id_i),
    .is_server_i   (is_server_i),
    .event_valid_i (event_valid_o),
    .event_kind_i  (event_kind_o),
    .event_client_i(event_client_o),
    .event_server_i(event_server_o),
    .last_i        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic idle_random();
    int unsigned n;
    if (no_gaps || $urandom_range(0, 1) == 0) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 3);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // holds start until the transaction is taken, then maybe idles
  task automatic send_command(input logic act, input logic [ID_W-1:0] id,
                              input logic srv);
    start       <= 1'b1;
    action_i    <= act;
    client_id_i <= id;
    is_server_i <= srv;
    do @(posedge clk_i); while (busy);
    idle_random();
  endtask

  task automatic ping(input logic [ID_W-1:0] id, input logic srv);
    send_command(ACT_PING, id, srv);
  endtask

  // id and server bits are don't-care on a tick
  task automatic tick();
    send_command(ACT_TICK, ID_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [TIME_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned      done;
    int unsigned      sel;
    logic [TIME_W-1:0] tmo;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timeout of 5
    ping(ID_W'(0), 1'b0);
    ping(ID_W'(CLIENT_SLOTS - 1), 1'b1);
    ping(ID_W'(CLIENT_SLOTS - 1), 1'b0);
    ping(ID_W'(CLIENT_SLOTS), 1'b1);
    ping(8'hFF, 1'b1);
    ping(8'hAA, 1'b0);
    repeat (6) tick();
    ping(ID_W'(5), 1'b1);
    tick();

    write_timeout('0);
    ping(ID_W'(10), 1'b0);
    ping(ID_W'(11), 1'b1);
    tick();
    tick();

    write_timeout('1);
    ping(ID_W'(20), 1'b1);
    repeat (3) tick();

    write_timeout(32'd1);
    tick();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       tmo = '0;
        1:       tmo = 32'd1;
        2:       tmo = $urandom_range(2, 6);
        3:       tmo = $urandom();
        4:       tmo = '1;
        default: tmo = $urandom_range(1, 3);
      endcase
      write_timeout(tmo);
      no_gaps = (p == 2);
      done = 0;
      while (done < PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          if ($urandom_range(0, 4) != 0) begin
            ping(ID_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
          end else begin
            ping(ID_W'($urandom_range(0, CLIENT_SLOTS - 1)), 1'($urandom_range(0, 1)));
          end
          done++;
        end else if (sel < 85) begin
          tick();
          done++;
        end else begin
          ping(ID_W'($urandom_range(CLIENT_SLOTS, 255)), 1'($urandom_range(0, 1)));
        end
      end
    end
    no_gaps = 1'b0;

    // fill the table, then lose every client on one tick
    write_timeout('0);
    for (int unsigned i = 0; i < CLIENT_SLOTS; i++) ping(ID_W'(i), 1'($urandom_range(0, 1)));
    tick();
    tick();

    wait_drained();
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
